// ===== hdl/shell_weighted_noise_accumulate_assert.svh =====
// assertion macros for the shell weighted noise accumulator
`ifndef SHELL_WEIGHTED_NOISE_ACCUMULATE_ASSERT_SVH
`define SHELL_WEIGHTED_NOISE_ACCUMULATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression must never hold out of reset
`define SWNA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("swna: forbidden condition seen");

// same-cycle implication
`define SWNA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swna: implication failed");

// next-cycle implication
`define SWNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swna: next-cycle implication failed");

`else

`define SWNA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define SWNA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SWNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/swna_pkg.sv =====
// shared types and constants of the shell weighted noise accumulator
package swna_pkg;

    localparam int unsigned PIX_W   = 16;
    localparam int unsigned SHELL_W = 9;
    localparam int unsigned NUM_W   = 8;
    localparam int unsigned SIU_W   = 9;
    localparam int unsigned ACC_W   = 63;
    localparam int unsigned INC_W   = 35;

    localparam logic [SIU_W-1:0] SIU_RESET = 9'd256;
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // pixel operands handed to the arithmetic pipeline
    typedef struct packed {
        logic signed [PIX_W-1:0] image_real;
        logic signed [PIX_W-1:0] image_imag;
        logic signed [PIX_W-1:0] proj_real;
        logic signed [PIX_W-1:0] proj_imag;
        logic signed [PIX_W-1:0] ctf_factor;
        logic [PIX_W-1:0]        pixel_weight;
    } t_pix;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_SQR   = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_READ  = 7'b1000000
    } t_state;

endpackage

// ===== hdl/swna_if.sv =====
// valid/ready channel interfaces for pixel input and shell sum output
interface swna_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [swna_pkg::PIX_W-1:0]   image_real;
    logic signed [swna_pkg::PIX_W-1:0]   image_imag;
    logic signed [swna_pkg::PIX_W-1:0]   proj_real;
    logic signed [swna_pkg::PIX_W-1:0]   proj_imag;
    logic signed [swna_pkg::PIX_W-1:0]   ctf_factor;
    logic [swna_pkg::PIX_W-1:0]          pixel_weight;
    logic signed [swna_pkg::SHELL_W-1:0] shell;

    modport source (
        output valid, action, image_real, image_imag, proj_real, proj_imag,
               ctf_factor, pixel_weight, shell,
        input  ready
    );
    modport sink (
        input  valid, action, image_real, image_imag, proj_real, proj_imag,
               ctf_factor, pixel_weight, shell,
        output ready
    );
endinterface

interface swna_out_if;
    logic                        valid;
    logic                        ready;
    logic [swna_pkg::ACC_W-1:0]  shell_sum;
    logic [swna_pkg::NUM_W-1:0]  shell_number;

    modport source (output valid, shell_sum, shell_number, input ready);
    modport sink   (input valid, shell_sum, shell_number, output ready);
endinterface

// ===== hdl/swna_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module swna_ram #(
    parameter int unsigned WIDTH = 63,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/swna_math.sv =====
// four-stage residual power and weight pipeline
module swna_math (
    input  logic                              i_clk,
    input  swna_pkg::t_pix                    i_pix,
    output logic [swna_pkg::INC_W-1:0]        o_incr
);
    import swna_pkg::*;

    logic signed [PIX_W-1:0]   ctf;
    logic signed [PIX_W-1:0]   pre;
    logic signed [PIX_W-1:0]   pim;
    logic signed [2*PIX_W-1:0] prod_re;
    logic signed [2*PIX_W-1:0] prod_im;

    logic signed [2*PIX_W-1:0] r_prod_re;
    logic signed [2*PIX_W-1:0] r_prod_im;
    logic [PIX_W-1:0]          r_img_re;
    logic [PIX_W-1:0]          r_img_im;
    logic [PIX_W-1:0]          r_w1;

    logic signed [18:0]        d_re;
    logic signed [18:0]        d_im;
    logic signed [37:0]        sq_re;
    logic signed [37:0]        sq_im;
    logic [33:0]               r_sq_re;
    logic [33:0]               r_sq_im;
    logic [PIX_W-1:0]          r_w2;

    logic [INC_W-1:0]          r_mag;
    logic [PIX_W-1:0]          r_w3;
    logic [INC_W+PIX_W-1:0]    wprod;
    logic [INC_W-1:0]          r_incr;

    assign ctf     = i_pix.ctf_factor;
    assign pre     = i_pix.proj_real;
    assign pim     = i_pix.proj_imag;
    assign prod_re = 32'(ctf) * 32'(pre);
    assign prod_im = 32'(ctf) * 32'(pim);

    // floor of product / 2^14 minus image, in 19 bits
    assign d_re = {r_prod_re[31], r_prod_re[31:14]}
                - {{3{r_img_re[15]}}, r_img_re};
    assign d_im = {r_prod_im[31], r_prod_im[31:14]}
                - {{3{r_img_im[15]}}, r_img_im};
    assign sq_re = 38'(d_re) * 38'(d_re);
    assign sq_im = 38'(d_im) * 38'(d_im);

    assign wprod = (INC_W+PIX_W)'(r_mag) * (INC_W+PIX_W)'(r_w3);

    always_ff @(posedge i_clk) begin
        r_prod_re <= prod_re;
        r_prod_im <= prod_im;
        r_img_re  <= i_pix.image_real;
        r_img_im  <= i_pix.image_imag;
        r_w1      <= i_pix.pixel_weight;

        r_sq_re   <= sq_re[33:0];
        r_sq_im   <= sq_im[33:0];
        r_w2      <= r_w1;

        r_mag     <= {1'b0, r_sq_re} + {1'b0, r_sq_im};
        r_w3      <= r_w2;

        r_incr    <= wprod[INC_W+PIX_W-1:PIX_W];
    end

    assign o_incr = r_incr;

endmodule

// ===== hdl/shell_weighted_noise_accumulate.sv =====
// top level of the per-shell weighted noise power accumulator
// Each accumulate transfer carries an image pixel, a projected reference pixel, a Q2.14 CTF
// value, a Q0.16 weight and a shell; the weighted squared magnitude of ctf*proj - image is
// added, with saturation at 2^63-1, to that shell's accumulator held in one ram of
// NUM_SHELLS entries. A read transfer returns the shell's sum and clears it. The block works
// on one item at a time: an accumulate passes through the four-stage multiply pipeline
// and then the ram write-back, a read waits for the registered ram read data,
// and an item that is skipped (negative shell, or outside the active range) leaves it idle.
// A result waits in an output register; the next item is taken while it waits, and only a
// second read stalls until the first result is transferred. After reset the ram is cleared
// one entry per cycle, through all NUM_SHELLS entries, during which no input item is taken;
// shells_in_use may be written at any idle time through i_cfg_we / i_cfg_wdata.
module shell_weighted_noise_accumulate #(
    parameter int unsigned NUM_SHELLS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swna_pkg::SIU_W-1:0]  i_cfg_wdata,
    swna_in_if.sink                     i_in,
    swna_out_if.source                  o_out
);
    import swna_pkg::*;

    localparam int unsigned    AW         = $clog2(NUM_SHELLS);
    localparam logic [AW-1:0]  LAST_SHELL = AW'(NUM_SHELLS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [SIU_W-1:0]  r_siu;
    logic [AW-1:0]     r_clr_cnt;
    logic [NUM_W-1:0]  r_shell;
    logic              r_out_valid;
    logic [ACC_W-1:0]  r_out_sum;
    logic [NUM_W-1:0]  r_out_num;

    logic              accept;
    logic              shell_pos;
    logic              in_range;
    logic              accum_ok;
    logic              read_ok;
    logic              out_free;
    t_pix              pix;
    logic [INC_W-1:0]  incr;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_new;
    logic [ACC_W-1:0]  rdata;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ACC_W-1:0]  ram_wdata;

    // input handshake: items are taken only while idle
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // shell qualification; a skipped item leaves the ram contents untouched
    assign shell_pos = !i_in.shell[SHELL_W-1];
    assign in_range  = 32'(i_in.shell[NUM_W-1:0]) < 32'(NUM_SHELLS);
    assign accum_ok  = shell_pos && in_range
                    && ({1'b0, i_in.shell[NUM_W-1:0]} < r_siu);
    assign read_ok   = shell_pos && in_range;

    // output slot can take a new result this cycle
    assign out_free  = !r_out_valid || o_out.ready;

    // operands go to the arithmetic pipeline every cycle; stage 1 holds the accepted ones
    assign pix.image_real   = i_in.image_real;
    assign pix.image_imag   = i_in.image_imag;
    assign pix.proj_real    = i_in.proj_real;
    assign pix.proj_imag    = i_in.proj_imag;
    assign pix.ctf_factor   = i_in.ctf_factor;
    assign pix.pixel_weight = i_in.pixel_weight;

    swna_math u_math (
        .i_clk  (i_clk),
        .i_pix  (pix),
        .o_incr (incr)
    );

    // the ram read is launched on the accepting edge; data holds until the next transfer
    swna_ram #(
        .WIDTH (ACC_W),
        .DEPTH (NUM_SHELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_in.shell[NUM_W-1:0])),
        .o_rdata (rdata)
    );

    // saturating accumulate: bit 63 of the sum flags overflow past 2^63-1
    assign acc_sum = {1'b0, rdata} + (ACC_W+1)'(incr);
    assign acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    // write port: clearing pass, read-and-clear, or accumulate write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_shell);
        ram_wdata = '0;
        unique case (r_state) inside
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
            end
            S_READ: begin
                ram_we    = out_free;
            end
            S_UPD: begin
                ram_we    = 1'b1;
                ram_wdata = acc_new;
            end
            S_IDLE, S_MUL, S_SQR, S_SUM: begin
                ram_we    = 1'b0;
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_SHELL) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_in.action == ACT_READ) begin
                        if (read_ok) n_state = S_READ;
                    end else if (accum_ok) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL:  n_state = S_SQR;
            S_SQR:  n_state = S_SUM;
            S_SUM:  n_state = S_UPD;
            S_UPD:  n_state = S_IDLE;
            S_READ: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_siu       <= SIU_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cfg_we) begin
                r_siu <= i_cfg_wdata;
            end
            if (r_state == S_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shell <= i_in.shell[NUM_W-1:0];
        end
        if (r_state == S_READ && out_free) begin
            r_out_sum <= rdata;
            r_out_num <= r_shell;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.shell_sum    = r_out_sum;
    assign o_out.shell_number = r_out_num;

    `include "shell_weighted_noise_accumulate_assert.svh"

    // the ram is never written while idle, so a skipped item cannot disturb a shell
    `SWNA_ASSERT_NEVER(a_no_idle_write, i_clk, i_rst_n, ram_we && (r_state == S_IDLE))

    // a new result only ever comes out of the read state
    `SWNA_ASSERT_IMPLIES(a_result_from_read, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_READ)

    // a qualified accumulate transfer always enters the arithmetic pipeline
    `SWNA_ASSERT_NEXT(a_accum_starts, i_clk, i_rst_n,
        accept && (i_in.action == ACT_ACCUM) && accum_ok, r_state == S_MUL)

endmodule
